// File: rtl/core/byte_addressed_data_memory_defines.svh
// Assertion macros for the byte-addressed data memory.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef BYTE_ADDRESSED_DATA_MEMORY_DEFINES_SVH
`define BYTE_ADDRESSED_DATA_MEMORY_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DBM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dbm: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DBM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dbm: next-cycle check failed");

`endif

// File: rtl/core/dbm_pkg.sv
// Shared types, constants and helper functions for the byte-addressed data memory.
// Depends on nothing; every module of the block but dbm_ram imports it.
package dbm_pkg;

	// Capacity in bytes and the bank arrangement derived from it.
	localparam int MEM_BYTES = 65536;
	localparam int NBANK     = 4;
	localparam int ROW_W     = ($clog2(MEM_BYTES) > 3) ? ($clog2(MEM_BYTES) - 2) : 1;
	localparam int BANK_ROWS = 1 << ROW_W;

	// Limit register.
	localparam int LIMIT_W = 17;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);

	// Command and access size codes; the last size code is reserved and always refused.
	localparam logic       CMD_READ  = 1'b0;
	localparam logic       CMD_WRITE = 1'b1;
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;
	localparam logic [1:0] SIZE_BAD  = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  access_size;
		logic [31:0] address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        out_of_bounds;
	} rsp_t;

	// Per-bank memory request produced from one access.
	typedef struct packed {
		logic [NBANK-1:0]            we;
		logic [NBANK-1:0][ROW_W-1:0] row;
		logic [NBANK-1:0][7:0]       wdata;
	} bank_req_t;

	// What the read side needs to know about an access in flight.
	typedef struct packed {
		logic       rd;
		logic       oob;
		logic [1:0] size;
		logic [1:0] offset;
	} meta_t;

	// Byte lanes that an access of the given size touches.
	function automatic logic [NBANK-1:0] lane_mask(input logic [1:0] size);
		logic [NBANK-1:0] m;
		case (size)
			SIZE_BYTE: m = 4'b0001;
			SIZE_HALF: m = 4'b0011;
			SIZE_WORD: m = 4'b1111;
			default:   m = 4'b0000;
		endcase
		return m;
	endfunction

	// Number of bytes minus one for a legal size.
	function automatic logic [1:0] size_span(input logic [1:0] size);
		logic [1:0] s;
		case (size)
			SIZE_BYTE: s = 2'd0;
			SIZE_HALF: s = 2'd1;
			SIZE_WORD: s = 2'd3;
			default:   s = 2'd0;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/core/dbm_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing; one instance serves each byte bank.
module dbm_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A write stores the data; a read returns the entry from a register in the next cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/core/dbm_addr_gen.sv
// Bounds check and bank steering for one access of the data memory.
// Depends on dbm_pkg.
module dbm_addr_gen (
	input  dbm_pkg::req_t                  req,
	input  logic [dbm_pkg::LIMIT_W-1:0]    limit,
	output dbm_pkg::bank_req_t             bank,
	output dbm_pkg::meta_t                 meta
);
	import dbm_pkg::*;

	logic [32:0]      last_addr;
	logic [32:0]      eff_limit;
	logic             fail;
	logic [1:0]       offset;
	logic [ROW_W-1:0] row0;
	logic [NBANK-1:0] lanes;
	logic [1:0]       lane [NBANK];

	// The end address is formed one bit wider so that it cannot wrap.
	assign last_addr = {1'b0, req.address} + {31'b0, size_span(req.access_size)};
	assign eff_limit = (33'(limit) > 33'(MEM_BYTES)) ? 33'(MEM_BYTES) : 33'(limit);
	assign fail      = (req.access_size == SIZE_BAD) || (last_addr >= eff_limit);

	assign offset = req.address[1:0];
	assign row0   = req.address[ROW_W+1:2];
	assign lanes  = lane_mask(req.access_size);

	// Each bank takes the byte lane that falls on it; banks below the start
	// offset hold the bytes that spill into the next row.
	always_comb begin
		for (int b = 0; b < NBANK; b++) begin
			lane[b]        = 2'(b) - offset;
			bank.row[b]    = row0 + ((2'(b) < offset) ? ROW_W'(1) : ROW_W'(0));
			bank.we[b]     = (req.cmd == CMD_WRITE) && !fail && lanes[lane[b]];
			bank.wdata[b]  = req.write_data[{lane[b], 3'b000} +: 8];
		end
	end

	assign meta.rd     = (req.cmd == CMD_READ);
	assign meta.oob    = fail;
	assign meta.size   = req.access_size;
	assign meta.offset = offset;

endmodule

// File: rtl/core/dbm_rsp_align.sv
// Reassembles the little-endian read value from the four bank outputs.
// Depends on dbm_pkg.
module dbm_rsp_align (
	input  dbm_pkg::meta_t                   meta,
	input  logic [dbm_pkg::NBANK-1:0][7:0]   bank_rdata,
	output dbm_pkg::rsp_t                    rsp
);
	import dbm_pkg::*;

	logic [NBANK-1:0] lanes;
	logic             keep;

	assign lanes = lane_mask(meta.size);
	assign keep  = meta.rd && !meta.oob;

	// Byte lane i of the result comes from bank (offset + i), masked by size.
	always_comb begin
		rsp.out_of_bounds = meta.oob;
		for (int i = 0; i < NBANK; i++) begin
			rsp.read_data[8*i +: 8] = (keep && lanes[i]) ? bank_rdata[2'(i) + meta.offset]
			                                              : 8'h00;
		end
	end

endmodule

// File: rtl/core/byte_addressed_data_memory.sv
// Top level of the byte-addressed data memory: four byte-bank RAMs and the access pipeline.
// Depends on dbm_pkg, dbm_addr_gen, dbm_ram, dbm_rsp_align and the defines header.
//
//   channel   direction  handshake           payload
//   req       in         req_valid/req_stall req_t (cmd, access_size, address, write_data)
//   rsp       out        rsp_valid/rsp_stall rsp_t (read_data, out_of_bounds)
//   cfg       in         cfg_valid/cfg_ready cfg_data (limit in bytes)
//
// One request is taken per cycle while req_stall is low; the accepting edge reads the banks into
// the middle stage, and the response register takes the result once it is free.
// The four byte banks are read or written at the accepting edge, so an unaligned
// word is served in one pass and back-to-back accesses never meet the same edge.
// Reset clears the pipeline valids and sets the limit to 65536; memory content is
// undefined until written. A stalled response holds the middle stage, and the
// request side stalls only while the middle stage is full and the response is stalled.
`include "byte_addressed_data_memory_defines.svh"

module byte_addressed_data_memory (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  dbm_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output dbm_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dbm_pkg::LIMIT_W-1:0]   cfg_data
);
	import dbm_pkg::*;

	logic [LIMIT_W-1:0]    limit_q;
	bank_req_t             bank;
	meta_t                 meta;
	meta_t                 meta_s1;
	logic                  valid_s1;
	logic [NBANK-1:0][7:0] bank_rdata;
	rsp_t                  rsp_next;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic                  req_acc;
	logic                  out_free;

	// Limit register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// Handshake: the middle stage moves on whenever the response register is free.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !out_free;
	assign req_acc   = req_valid && !req_stall;

	dbm_addr_gen u_addr_gen (
		.req   (req),
		.limit (limit_q),
		.bank  (bank),
		.meta  (meta)
	);

	// Byte banks, accessed at the accepting edge.
	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		dbm_ram #(
			.DEPTH (BANK_ROWS),
			.WIDTH (8)
		) u_ram (
			.clk   (clk),
			.en    (req_acc),
			.we    (bank.we[b]),
			.addr  (bank.row[b]),
			.wdata (bank.wdata[b]),
			.rdata (bank_rdata[b])
		);
	end

	// Middle stage: access description waiting for the bank read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_acc || (valid_s1 && !out_free);
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			meta_s1 <= meta;
		end
	end

	dbm_rsp_align u_rsp_align (
		.meta       (meta_s1),
		.bank_rdata (bank_rdata),
		.rsp        (rsp_next)
	);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A refused access never writes any bank.
	`DBM_ASSERT_IMP(a_oob_no_write, req_acc && meta.oob, bank.we == '0)
	// A refused access always answers with zero data.
	`DBM_ASSERT_IMP(a_oob_zero_data, rsp_valid && rsp.out_of_bounds, rsp.read_data == '0)
	// Every accepted request occupies the middle stage on the next cycle.
	`DBM_ASSERT_NXT(a_acc_fills_s1, req_acc, valid_s1)
	// A blocked response keeps the middle stage and its description intact.
	`DBM_ASSERT_NXT(a_s1_held, valid_s1 && rsp_valid_q && rsp_stall, valid_s1 && $stable(meta_s1))

endmodule

// File: bench/tb.sv
// Self-checking testbench for the byte-addressed data memory: directed and random accesses.
// Depends on dbm_pkg and the byte_addressed_data_memory top level; a scoreboard class
// predicts every response and plain tasks drive the request and limit channels.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dbm_pkg::*;

	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         MAX_REPORTS    = 40;

	// Memory image and limit as the block should hold them, plus the queue of
	// responses still owed by the block.
	class access_scoreboard;
		logic [7:0]        store [0:MEM_BYTES-1];
		logic [LIMIT_W-1:0] limit = LIMIT_RESET;
		rsp_t              expected_q[$];
		int                errors = 0;

		function int bytes_in(logic [1:0] size);
			case (size)
				SIZE_BYTE: return 1;
				SIZE_HALF: return 2;
				SIZE_WORD: return 4;
				default:   return 0;
			endcase
		endfunction

		// The configured limit never counts beyond the physical capacity.
		function int eff_limit();
			return (int'(limit) > MEM_BYTES) ? MEM_BYTES : int'(limit);
		endfunction

		// The end address is worked out in 64 bits so that it cannot wrap.
		function bit fits(logic [31:0] addr, logic [1:0] size);
			longint last_byte;
			if (bytes_in(size) == 0)
				return 1'b0;
			last_byte = longint'(addr) + bytes_in(size) - 1;
			return last_byte < eff_limit();
		endfunction

		function void note_access(req_t r);
			rsp_t e;
			int   base;
			e = '0;
			base = int'(r.address[15:0]);
			if (!fits(r.address, r.access_size)) begin
				e.out_of_bounds = 1'b1;
			end else begin
				for (int i = 0; i < bytes_in(r.access_size); i++) begin
					if (r.cmd == CMD_WRITE)
						store[base + i] = r.write_data[8*i +: 8];
					else
						e.read_data[8*i +: 8] = store[base + i];
				end
			end
			expected_q.push_back(e);
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: response with none expected: read_data %h out_of_bounds %b",
						$time, got.read_data, got.out_of_bounds);
				return;
			end
			want = expected_q.pop_front();
			if (got.read_data !== want.read_data) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: read_data expected %h, actual %h",
						$time, want.read_data, got.read_data);
			end
			if (got.out_of_bounds !== want.out_of_bounds) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: out_of_bounds expected %b, actual %b",
						$time, want.out_of_bounds, got.out_of_bounds);
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	req_t               req;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data;

	access_scoreboard sb = new;

	// Bytes that hold a known value, so that reads never touch an unwritten entry.
	bit               filled [0:MEM_BYTES-1];
	bit               calm = 1'b0;
	int               stall_left = 0;
	int               quiet_cycles = 0;
	logic [1:0]       sizes [3] = '{SIZE_BYTE, SIZE_HALF, SIZE_WORD};

	byte_addressed_data_memory DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Response side holds off in random bursts until the closing stretch.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			if (!calm && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 18);
		end
	end

	// Every accepted response is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_reply(rsp);
	end

	// Watchdog: too long without any handshake means the block has hung.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it.
	task automatic send_access(input req_t r);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_access(r);
	endtask

	function automatic bit all_filled(logic [31:0] addr, logic [1:0] size);
		for (int i = 0; i < sb.bytes_in(size); i++) begin
			if (!filled[int'(addr[15:0]) + i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// A read that would meet unwritten bytes is turned into a write there.
	task automatic issue(input req_t r);
		if (r.cmd == CMD_READ && sb.fits(r.address, r.access_size)
				&& !all_filled(r.address, r.access_size))
			r.cmd = CMD_WRITE;
		if (r.cmd == CMD_WRITE && sb.fits(r.address, r.access_size)) begin
			for (int i = 0; i < sb.bytes_in(r.access_size); i++)
				filled[int'(r.address[15:0]) + i] = 1'b1;
		end
		send_access(r);
	endtask

	task automatic sender_gap();
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18))
				@(posedge clk);
		end
	endtask

	// Stop requesting and wait until every response has come back.
	task automatic drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.outstanding() != 0);
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.limit = value;
	endtask

	// Edges of the address space, unaligned spans, bad sizes and refused writes.
	task automatic directed();
		issue(req_t'{CMD_WRITE, SIZE_BYTE, 32'd0, 32'hFFFF_FFA5});
		issue(req_t'{CMD_WRITE, SIZE_HALF, 32'd1, 32'h1234_BEEF});
		issue(req_t'{CMD_WRITE, SIZE_WORD, 32'd3, 32'hDEAD_C0DE});
		issue(req_t'{CMD_WRITE, SIZE_WORD, 32'd7, 32'h89AB_CDEF});
		issue(req_t'{CMD_READ,  SIZE_WORD, 32'd0, 32'hFFFF_FFFF});
		issue(req_t'{CMD_READ,  SIZE_WORD, 32'd5, 32'd0});
		issue(req_t'{CMD_READ,  SIZE_HALF, 32'd1, 32'd0});
		issue(req_t'{CMD_READ,  SIZE_BYTE, 32'd2, 32'd0});
		issue(req_t'{CMD_READ,  SIZE_WORD, 32'd6, 32'd0});
		issue(req_t'{CMD_WRITE, SIZE_WORD, 32'd65532, 32'hCAFE_F00D});
		issue(req_t'{CMD_READ,  SIZE_WORD, 32'd65532, 32'd0});
		issue(req_t'{CMD_WRITE, SIZE_BYTE, 32'd65535, 32'h0000_005A});
		issue(req_t'{CMD_READ,  SIZE_BYTE, 32'd65535, 32'd0});
		issue(req_t'{CMD_READ,  SIZE_HALF, 32'd65535, 32'd0});
		issue(req_t'{CMD_WRITE, SIZE_WORD, 32'd65533, 32'h7777_7777});
		issue(req_t'{CMD_READ,  SIZE_WORD, 32'd65533, 32'd0});
		issue(req_t'{CMD_WRITE, SIZE_BYTE, 32'd65536, 32'h0000_0011});
		issue(req_t'{CMD_WRITE, SIZE_WORD, 32'hFFFF_FFFF, 32'h1111_1111});
		issue(req_t'{CMD_READ,  SIZE_HALF, 32'hFFFF_FFFF, 32'd0});
		issue(req_t'{CMD_WRITE, SIZE_BAD,  32'd0, 32'h5555_5555});
		issue(req_t'{CMD_READ,  SIZE_BAD,  32'd0, 32'd0});
		issue(req_t'{CMD_READ,  SIZE_WORD, 32'd0, 32'd0});
		issue(req_t'{CMD_WRITE, SIZE_WORD, 32'h8000_0000, 32'h2222_2222});
		issue(req_t'{CMD_READ,  SIZE_BYTE, 32'd65535, 32'd0});
	endtask

	// Random requests, weighted towards a small written window and the limit edge.
	task automatic run_random(input int count);
		req_t r;
		int   eff;
		int   pick;
		for (int i = 0; i < count; i++) begin
			eff = sb.eff_limit();
			r.cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
			r.access_size = ($urandom_range(0, 31) == 0) ? SIZE_BAD : sizes[$urandom_range(0, 2)];
			r.write_data = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 45)
				r.address = $urandom_range(0, 63);
			else if (pick < 65)
				r.address = eff - 5 + $urandom_range(0, 8);
			else if (pick < 80)
				r.address = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
			else if (pick < 90)
				r.address = 32'hFFFF_FFF8 + $urandom_range(0, 7);
			else
				r.address = $urandom;
			issue(r);
			sender_gap();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();
		drain();
		set_limit(LIMIT_RESET);
		run_random(110);
		drain();
		set_limit('0);
		run_random(15);
		drain();
		set_limit(LIMIT_W'(1));
		run_random(15);
		drain();
		set_limit(LIMIT_W'($urandom_range(4, 1024)));
		run_random(90);
		drain();
		set_limit(LIMIT_RESET - 1'b1);
		run_random(60);
		drain();
		set_limit(LIMIT_RESET);
		run_random(50);

		// Closing stretch at full rate on both sides.
		calm = 1'b1;
		run_random(60);
		drain();
		repeat (8)
			@(posedge clk);

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: byte_addressed_data_memory.f
+incdir+rtl/core
rtl/core/dbm_pkg.sv
rtl/core/dbm_ram.sv
rtl/core/dbm_addr_gen.sv
rtl/core/dbm_rsp_align.sv
rtl/core/byte_addressed_data_memory.sv
bench/tb.sv
